// File: src/blktc_pkg.sv
// blktc_pkg: constants, register codes and controller/datapath interface types
// for the block transposition cipher. No dependencies.
package blktc_pkg;

	localparam int ENTRY_BITS  = 3;
	localparam int NUM_ENTRIES = 8;
	localparam int PERM_BITS   = ENTRY_BITS * NUM_ENTRIES;
	localparam int KEYLEN_BITS = 4;

	localparam logic [7:0] PAD_CHAR = 8'h20;

	localparam logic [1:0] REG_KEY_LENGTH   = 2'd0;
	localparam logic [1:0] REG_PERMUTATION  = 2'd1;
	localparam logic [1:0] REG_DECRYPT_MODE = 2'd2;

	localparam logic [KEYLEN_BITS-1:0] KEY_LENGTH_RESET  = 4'd8;
	localparam logic [PERM_BITS-1:0]   PERMUTATION_RESET = 24'hFAC688;

	typedef struct packed {
		logic store;
		logic close;
		logic emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic block_done;
		logic pos_last;
		logic out_free;
	} dp_status_t;

endpackage

// File: src/blktc_ctrl.sv
// blktc_ctrl: fill/emit state machine of the block transposition cipher.
// Depends on blktc_pkg for the command and status types.
module blktc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  blktc_pkg::dp_status_t status,
	output blktc_pkg::ctrl_cmd_t  cmd
);

	localparam logic ST_FILL = 1'b0;
	localparam logic ST_EMIT = 1'b1;

	logic state_q;
	logic state_d;

	assign in_ready  = (state_q == ST_FILL);
	assign cmd.store = in_valid && in_ready;
	assign cmd.close = cmd.store && status.block_done;
	assign cmd.emit  = (state_q == ST_EMIT) && status.out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_FILL: begin
				if (cmd.close) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (cmd.emit && status.pos_last) state_d = ST_FILL;
			end
			default: state_d = ST_FILL;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
		end else begin
			state_q <= state_d;
		end
	end

	a_close_to_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.close |=> (state_q == ST_EMIT))
		else $error("closed block did not start emitting");

endmodule

// File: src/blktc_datapath.sv
// blktc_datapath: block buffer, fill and position counters, permutation lookup
// and output register. Depends on blktc_pkg.
module blktc_datapath #(
	parameter int MAX_KEY     = 8,
	parameter int SYMBOL_BITS = 16,
	parameter int CW          = $clog2(MAX_KEY + 1)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  blktc_pkg::ctrl_cmd_t             cmd,
	output blktc_pkg::dp_status_t            status,
	input  logic [SYMBOL_BITS-1:0]           symbol,
	input  logic                             text_end,
	input  logic [CW-1:0]                    key_len,
	input  logic [blktc_pkg::PERM_BITS-1:0]  permutation,
	input  logic                             decrypt,
	input  logic                             out_ready,
	output logic                             out_valid,
	output logic [SYMBOL_BITS-1:0]           out_symbol,
	output logic                             block_end,
	output logic                             stream_end
);

	localparam int IW = $clog2(MAX_KEY);
	localparam int SW = (IW > blktc_pkg::ENTRY_BITS) ? IW : blktc_pkg::ENTRY_BITS;

	logic [SYMBOL_BITS-1:0] blk_q [MAX_KEY];
	logic [CW-1:0] fill_q;
	logic [IW-1:0] pos_q;
	logic [CW-1:0] n_q;
	logic          last_q;
	logic          out_valid_q;
	logic [SYMBOL_BITS-1:0] out_symbol_q;
	logic          block_end_q;
	logic          stream_end_q;

	logic [CW-1:0] fill_next;
	logic [CW-1:0] n_next;
	logic [blktc_pkg::ENTRY_BITS-1:0] entry [MAX_KEY];
	logic [SW-1:0] src;
	logic          found;
	logic          take;
	logic [SYMBOL_BITS-1:0] next_sym;

	for (genvar j = 0; j < MAX_KEY; j++) begin : g_entry
		if (j < blktc_pkg::NUM_ENTRIES) begin : g_reg
			assign entry[j] = permutation[blktc_pkg::ENTRY_BITS*j +: blktc_pkg::ENTRY_BITS];
		end else begin : g_zero
			assign entry[j] = '0;
		end
	end

	assign fill_next = fill_q + CW'(1);
	assign n_next    = (fill_next < key_len) ? fill_next : key_len;

	assign status.block_done = (fill_next >= key_len) || text_end;
	assign status.pos_last   = ((CW'(pos_q) + CW'(1)) == key_len);
	assign status.out_free   = !out_valid_q || out_ready;

	// decrypt: first position whose entry names this output
	always_comb begin
		src   = '0;
		found = 1'b0;
		if (decrypt) begin
			for (int j = MAX_KEY - 1; j >= 0; j--) begin
				if ((32'(j) < 32'(key_len)) && (SW'(entry[j]) == SW'(pos_q))) begin
					found = 1'b1;
					src   = SW'(j);
				end
			end
		end else begin
			src   = SW'(entry[pos_q]);
			found = 1'b1;
		end
	end

	// past the held count the block is padding
	assign take     = found && (32'(src) < 32'(n_q));
	assign next_sym = take ? blk_q[src[IW-1:0]] : SYMBOL_BITS'(blktc_pkg::PAD_CHAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.store) begin
				fill_q <= cmd.close ? '0 : fill_next;
			end
			if (cmd.close) begin
				pos_q <= '0;
			end else if (cmd.emit) begin
				pos_q <= pos_q + IW'(1);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store && (fill_q < CW'(MAX_KEY))) begin
			blk_q[fill_q[IW-1:0]] <= symbol;
		end
		if (cmd.close) begin
			n_q    <= n_next;
			last_q <= text_end;
		end
		if (cmd.emit) begin
			out_symbol_q <= next_sym;
			block_end_q  <= status.pos_last;
			stream_end_q <= status.pos_last && last_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_symbol = out_symbol_q;
	assign block_end  = block_end_q;
	assign stream_end = stream_end_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(MAX_KEY))
		else $error("fill count beyond block buffer");

	a_emit_pos: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (CW'(pos_q) < key_len))
		else $error("emit position beyond key length");

	a_stream_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && stream_end) |-> block_end)
		else $error("stream end without block end");

endmodule

// File: src/block_transposition_cipher.sv
// Block transposition cipher. Symbols are taken one a cycle into a block buffer
// until key_length are held or a symbol marked text_end arrives; the block is
// then given out, one result a cycle while the output is not stalled, as key_length
// permuted symbols (a part block is padded with spaces), and no input is taken while
// it is given out. Fill and emit share the one block buffer, so a new block is
// taken only after the last one is given out. Registers: key_length at 0x0,
// permutation at 0x4, decrypt_mode at 0x8; write them only while the block is idle.
module block_transposition_cipher #(
	parameter int MAX_KEY     = 8,
	parameter int SYMBOL_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [3:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [SYMBOL_BITS-1:0] symbol,
	input  logic                   text_end,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [SYMBOL_BITS-1:0] out_symbol,
	output logic                   block_end,
	output logic                   stream_end
);

	localparam int CW = $clog2(MAX_KEY + 1);

	logic [blktc_pkg::KEYLEN_BITS-1:0] key_length_q;
	logic [blktc_pkg::PERM_BITS-1:0]   permutation_q;
	logic                              decrypt_mode_q;
	logic                              wr_en;
	logic [1:0]                        reg_idx;
	logic [31:0]                       kl_ext;
	logic [CW-1:0]                     key_len;

	blktc_pkg::ctrl_cmd_t  cmd;
	blktc_pkg::dp_status_t status;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_length_q   <= blktc_pkg::KEY_LENGTH_RESET;
			permutation_q  <= blktc_pkg::PERMUTATION_RESET;
			decrypt_mode_q <= 1'b0;
		end else if (wr_en) begin
			case (reg_idx)
				blktc_pkg::REG_KEY_LENGTH:
					key_length_q <= pwdata[blktc_pkg::KEYLEN_BITS-1:0];
				blktc_pkg::REG_PERMUTATION:
					permutation_q <= pwdata[blktc_pkg::PERM_BITS-1:0];
				blktc_pkg::REG_DECRYPT_MODE:
					decrypt_mode_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			blktc_pkg::REG_KEY_LENGTH:   prdata = 32'(key_length_q);
			blktc_pkg::REG_PERMUTATION:  prdata = 32'(permutation_q);
			blktc_pkg::REG_DECRYPT_MODE: prdata = 32'(decrypt_mode_q);
			default:                     prdata = '0;
		endcase
	end

	// clamp key length to 2..MAX_KEY
	always_comb begin
		kl_ext = 32'(key_length_q);
		if (kl_ext < 32'd2) begin
			kl_ext = 32'd2;
		end else if (kl_ext > 32'(MAX_KEY)) begin
			kl_ext = 32'(MAX_KEY);
		end
	end
	assign key_len = kl_ext[CW-1:0];

	blktc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	blktc_datapath #(
		.MAX_KEY     (MAX_KEY),
		.SYMBOL_BITS (SYMBOL_BITS),
		.CW          (CW)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.symbol      (symbol),
		.text_end    (text_end),
		.key_len     (key_len),
		.permutation (permutation_q),
		.decrypt     (decrypt_mode_q),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.out_symbol  (out_symbol),
		.block_end   (block_end),
		.stream_end  (stream_end)
	);

endmodule

// File: test/blktc_checker.sv
// blktc_checker: watches the config port and both streams of block_transposition_cipher,
// predicts every permuted symbol and compares it with what the block gives out.
// Depends on blktc_pkg for register codes, reset values and the pad character.
`timescale 1ns / 100ps

module blktc_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [15:0] symbol,
	input  logic        text_end,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [15:0] out_symbol,
	input  logic        block_end,
	input  logic        stream_end,
	output int          pending,
	output int          fail_count
);

	localparam int MAX_KEY = blktc_pkg::NUM_ENTRIES;
	localparam logic [15:0] SPACE = {8'h00, blktc_pkg::PAD_CHAR};

	typedef struct packed {
		logic [15:0] sym;
		logic        blk_last;
		logic        txt_last;
	} cipher_out_t;

	logic [blktc_pkg::KEYLEN_BITS-1:0] key_len_q;
	logic [blktc_pkg::PERM_BITS-1:0]   perm_q;
	logic                              decrypt_q;
	logic [15:0]                       block_q [0:MAX_KEY-1];
	int unsigned                       held;
	cipher_out_t                       due_symbols [$];
	int                                mismatches = 0;

	assign fail_count = mismatches;

	function automatic int unsigned active_len();
		if (key_len_q < 2)
			return 2;
		if (key_len_q > MAX_KEY)
			return MAX_KEY;
		return 32'(key_len_q);
	endfunction

	function automatic int unsigned key_entry(input int unsigned j);
		return 32'(perm_q[blktc_pkg::ENTRY_BITS*j +: blktc_pkg::ENTRY_BITS]);
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
		input logic [15:0] want);
		$display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
		mismatches++;
	endtask

	// one accepted symbol: store it and, if the block closes, queue its permuted form
	task automatic absorb_symbol(input logic [15:0] sym, input logic last);
		int unsigned kl;
		int unsigned n;
		int unsigned src;
		bit          found;
		cipher_out_t r;
		kl = active_len();
		if (held < MAX_KEY)
			block_q[held] = sym;
		held++;
		if (held < kl && !last)
			return;
		n = (held < kl) ? held : kl;
		for (int unsigned p = n; p < MAX_KEY; p++)
			block_q[p] = SPACE;
		for (int unsigned p = 0; p < kl; p++) begin
			found = 1'b0;
			src = 0;
			if (decrypt_q) begin
				for (int unsigned j = 0; j < kl; j++) begin
					if (!found && key_entry(j) == p) begin
						found = 1'b1;
						src = j;
					end
				end
			end else begin
				src = key_entry(p);
				found = (src < kl);
			end
			r.sym = found ? block_q[src] : SPACE;
			r.blk_last = (p + 1 == kl);
			r.txt_last = last && (p + 1 == kl);
			due_symbols.insert(due_symbols.size(), r);
		end
		held = 0;
	endtask

	task automatic check_transfer();
		cipher_out_t want;
		if (due_symbols.size() == 0) begin
			report_mismatch("unexpected output transfer", out_symbol, 16'h0000);
			return;
		end
		want = due_symbols.pop_front();
		if (out_symbol !== want.sym)
			report_mismatch("out_symbol", out_symbol, want.sym);
		if (block_end !== want.blk_last)
			report_mismatch("block_end", {15'd0, block_end}, {15'd0, want.blk_last});
		if (stream_end !== want.txt_last)
			report_mismatch("stream_end", {15'd0, stream_end}, {15'd0, want.txt_last});
	endtask

	task automatic take_write(input logic [1:0] idx, input logic [31:0] data);
		case (idx)
			blktc_pkg::REG_KEY_LENGTH:   key_len_q = data[blktc_pkg::KEYLEN_BITS-1:0];
			blktc_pkg::REG_PERMUTATION:  perm_q = data[blktc_pkg::PERM_BITS-1:0];
			blktc_pkg::REG_DECRYPT_MODE: decrypt_q = data[0];
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_len_q = blktc_pkg::KEY_LENGTH_RESET;
			perm_q = blktc_pkg::PERMUTATION_RESET;
			decrypt_q = 1'b0;
			held = 0;
			due_symbols.delete();
			pending <= 0;
		end else begin
			if (out_valid && out_ready)
				check_transfer();
			if (in_valid && in_ready)
				absorb_symbol(symbol, text_end);
			if (psel && penable && pwrite && pready)
				take_write(paddr[3:2], pwdata);
			pending <= due_symbols.size();
		end
	end

endmodule

// File: test/tb.sv
// tb: stimulus and verdict for block_transposition_cipher; directed corner blocks, then
// random keys and texts with bursty input and stalling output. Checking is in blktc_checker.
// Depends on blktc_pkg, block_transposition_cipher and blktc_checker.
`timescale 1ns / 100ps

module tb;

	localparam int RANDOM_ITEMS = 385;
	localparam int IDLE_LIMIT   = 5000;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_PERIODIC
	} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [15:0] symbol = '0;
	logic        text_end = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] out_symbol;
	logic        block_end;
	logic        stream_end;
	int          pending;
	int          fail_count;

	int          burst_left = 0;
	int          items_sent = 0;
	int          idle_cycles = 0;
	int unsigned rx_tick = 0;
	rx_mode_t    rx_mode = RX_OPEN;

	block_transposition_cipher dut (.*);
	blktc_checker chk (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		rx_tick <= rx_tick + 1;
		if (rx_tick % 64 == 0)
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
		case (rx_mode)
			RX_OPEN:   out_ready <= 1'b1;
			RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
			RX_SPARSE: out_ready <= ($urandom_range(0, 4) == 0);
			default:   out_ready <= rx_tick[2];
		endcase
	end

	// only input transfers and expected output transfers keep the run alive
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready && pending != 0))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic send_symbol(input logic [15:0] sym, input logic last);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		symbol <= sym;
		text_end <= last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	// block idle: no transfer offered, nothing owed, then a wait for a silent store
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic configure(input logic [3:0] kl, input logic [23:0] perm, input logic dec);
		settle();
		write_reg(blktc_pkg::REG_KEY_LENGTH, {28'd0, kl});
		write_reg(blktc_pkg::REG_PERMUTATION, {8'd0, perm});
		write_reg(blktc_pkg::REG_DECRYPT_MODE, {31'd0, dec});
	endtask

	task automatic random_config(output int kl_eff);
		logic [3:0]  kl_reg;
		logic [23:0] perm;
		int          order [0:7];
		int          pick;
		int          tmp;
		if ($urandom_range(0, 9) == 0)
			kl_reg = 4'($urandom_range(0, 15));
		else
			kl_reg = 4'($urandom_range(2, 8));
		kl_eff = (kl_reg < 2) ? 2 : (kl_reg > 8) ? 8 : kl_reg;
		perm = 24'($urandom_range(0, 24'hFFFFFF));
		if ($urandom_range(0, 3) != 0) begin
			for (int i = 0; i < 8; i++)
				order[i] = i;
			for (int i = kl_eff - 1; i > 0; i--) begin
				pick = $urandom_range(0, i);
				tmp = order[i];
				order[i] = order[pick];
				order[pick] = tmp;
			end
			for (int i = 0; i < kl_eff; i++)
				perm[3*i +: 3] = 3'(order[i]);
		end
		configure(kl_reg, perm, 1'($urandom_range(0, 1)));
	endtask

	// noisy texts scatter text_end and may stop mid block
	task automatic send_text(input int len, input bit noisy);
		for (int i = 0; i < len; i++) begin
			if (noisy)
				send_symbol(16'($urandom_range(0, 16'hFFFF)), $urandom_range(0, 3) == 0);
			else
				send_symbol(16'($urandom_range(0, 16'hFFFF)), i == len - 1);
		end
	endtask

	initial begin
		logic [15:0] corner_syms [0:7];
		int          kl;
		int          len;
		int          random_start;
		corner_syms = '{16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555,
			16'h0001, 16'h8000, 16'h7FFF, 16'h0020};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset key: full block closed by text_end, no extra pad block
		for (int i = 0; i < 8; i++)
			send_symbol(corner_syms[i], i == 7);

		// part block padded, key entry past key length reads as space
		configure(4'd3, 24'h000142, 1'b0);
		send_symbol(16'h1234, 1'b0);
		send_symbol(16'hFEDC, 1'b1);

		// decrypt with a key that is not a permutation
		configure(4'd4, 24'hFFF609, 1'b1);
		for (int i = 0; i < 4; i++)
			send_symbol(16'($urandom_range(0, 16'hFFFF)), i == 3);

		// key length below range, all-zero key
		configure(4'd0, 24'h000000, 1'b0);
		send_symbol(16'hC0DE, 1'b0);
		send_symbol(16'h0BAD, 1'b0);

		// key length above range, all-ones key, decrypt
		configure(4'd15, 24'hFFFFFF, 1'b1);
		for (int i = 0; i < 3; i++)
			send_symbol(16'($urandom_range(0, 16'hFFFF)), i == 2);

		// key length lowered while a block is half full
		configure(4'd8, blktc_pkg::PERMUTATION_RESET, 1'b0);
		for (int i = 0; i < 5; i++)
			send_symbol(16'($urandom_range(0, 16'hFFFF)), 1'b0);
		settle();
		write_reg(blktc_pkg::REG_KEY_LENGTH, 32'd3);
		send_symbol(16'($urandom_range(0, 16'hFFFF)), 1'b0);

		random_start = items_sent;
		while (items_sent - random_start < RANDOM_ITEMS) begin
			random_config(kl);
			repeat ($urandom_range(1, 4)) begin
				if ($urandom_range(0, 7) == 0)
					len = $urandom_range(1, 3 * kl);
				else
					len = $urandom_range(1, kl + kl / 2);
				send_text(len, $urandom_range(0, 5) == 0);
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
